FILE: rtl/core/c3er_pkg.sv
// ----------------------------------------------------------------------------
// c3er_pkg
// Shared types, sizes and helpers of the 3x3 edge-replicating convolution.
// ----------------------------------------------------------------------------
package c3er_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned ADDR_W     = $clog2(MAX_WIDTH);
  // Width of column quantities; holds MAX_WIDTH and the 11-bit register.
  localparam int unsigned CMP_W      = (ADDR_W + 1 > 11) ? ADDR_W + 1 : 11;
  localparam int unsigned HGT_W      = 13;
  localparam int unsigned ROW_W      = HGT_W + 1;
  localparam int unsigned TOT_W      = CMP_W + HGT_W;
  localparam int unsigned PROD_W     = 25;
  localparam int unsigned SUM_W      = 28;
  localparam int unsigned MAG_W      = SUM_W - 1;
  localparam int unsigned STEP_W     = $clog2(MAG_W + 1);

  localparam logic [2:0] CFG_WIDTH   = 3'd0;
  localparam logic [2:0] CFG_HEIGHT  = 3'd1;
  localparam logic [2:0] CFG_KTOP    = 3'd2;
  localparam logic [2:0] CFG_KMID    = 3'd3;
  localparam logic [2:0] CFG_KBOT    = 3'd4;
  localparam logic [2:0] CFG_DIVISOR = 3'd5;

  typedef struct packed {
    logic       operation;
    logic [7:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] filtered_pixel;
    logic       frame_done;
  } out_item_t;

  typedef struct packed {
    logic [CMP_W-1:0] eff_w;
    logic [HGT_W-1:0] eff_h;
    logic [TOT_W-1:0] total;
    logic             restart;
  } geom_t;

  typedef struct packed {
    logic [47:0] k_top;
    logic [47:0] k_mid;
    logic [47:0] k_bot;
    logic [15:0] divisor;
  } arith_t;

  typedef struct packed {
    logic [8:0][7:0] view;
    logic            done;
  } job_t;

  typedef enum logic {F_ACC, F_UPD} f_state_e;
  typedef enum logic [1:0] {B_IDLE, B_MAC, B_DIV, B_OUT} b_state_e;

  function automatic logic signed [15:0] coeff(input arith_t a, input logic [3:0] idx);
    logic [15:0] c;
    c = 16'd0;
    case (idx)
      4'd0: c = a.k_top[15:0];
      4'd1: c = a.k_top[31:16];
      4'd2: c = a.k_top[47:32];
      4'd3: c = a.k_mid[15:0];
      4'd4: c = a.k_mid[31:16];
      4'd5: c = a.k_mid[47:32];
      4'd6: c = a.k_bot[15:0];
      4'd7: c = a.k_bot[31:16];
      4'd8: c = a.k_bot[47:32];
      default: c = 16'd0;
    endcase
    return $signed(c);
  endfunction

endpackage

FILE: rtl/core/c3er_front.sv
// ----------------------------------------------------------------------------
// c3er_front
// Accepts pixels and drains, keeps the line stores and the window, and hands
// edge-replaced 3x3 views to the queue.
// ----------------------------------------------------------------------------
module c3er_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  c3er_pkg::geom_t     geom_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  c3er_pkg::in_item_t  in_data_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output c3er_pkg::job_t      q_job_o
);

  c3er_pkg::f_state_e state_q, state_d;

  logic [c3er_pkg::ADDR_W-1:0] col_q, col_d;
  logic [c3er_pkg::ROW_W-1:0]  row_q, row_d;
  logic [c3er_pkg::TOT_W-1:0]  cnt_q, cnt_d;
  logic [8:0][7:0]             win_q, win_d;

  logic [7:0] store_a [c3er_pkg::MAX_WIDTH];
  logic [7:0] store_b [c3er_pkg::MAX_WIDTH];
  logic [7:0] rd_a_q, rd_b_q, pix_q;
  logic       ign_q;

  logic        accept, is_pixel, upd, last_col, mid, have, done;
  logic        top, bot, left, right;
  logic [8:0][7:0] view;
  logic [c3er_pkg::CMP_W-1:0] col_inc;
  logic [c3er_pkg::ROW_W-1:0] h_ext;

  assign accept   = in_valid_i && in_ready_o;
  assign h_ext    = {1'b0, geom_i.eff_h};
  assign is_pixel = row_q < h_ext;

  always_comb begin
    state_d = state_q;
    case (state_q)
      c3er_pkg::F_ACC: if (accept) state_d = c3er_pkg::F_UPD;
      c3er_pkg::F_UPD: state_d = c3er_pkg::F_ACC;
      default:         state_d = c3er_pkg::F_ACC;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    upd        = 1'b0;
    case (state_q)
      c3er_pkg::F_ACC: in_ready_o = !q_full_i;
      c3er_pkg::F_UPD: upd = !ign_q;
      default:         in_ready_o = 1'b0;
    endcase
  end

  // Item registers and line-store reads, taken at the transfer.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_a_q <= store_a[col_q];
      rd_b_q <= store_b[col_q];
      pix_q  <= is_pixel ? in_data_i.pixel_value : 8'd0;
      ign_q  <= is_pixel && in_data_i.operation;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      store_a[col_q] <= pix_q;
      store_b[col_q] <= rd_a_q;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r*3]   = win_q[r*3+1];
      win_d[r*3+1] = win_q[r*3+2];
    end
    win_d[2] = rd_b_q;
    win_d[5] = rd_a_q;
    win_d[8] = pix_q;

    last_col = (col_q == '0) && (row_q >= c3er_pkg::ROW_W'(2));
    mid      = (col_q != '0) && (row_q >= c3er_pkg::ROW_W'(1));
    have     = last_col || mid;

    view = win_d;
    top  = (row_q == c3er_pkg::ROW_W'(1));
    bot  = (row_q == h_ext);
    left = (col_q == c3er_pkg::ADDR_W'(1));
    right = 1'b0;
    if (last_col) begin
      // The right-hand column of the previous row, seen before the shift.
      for (int r = 0; r < 3; r++) begin
        view[r*3]   = win_q[r*3+1];
        view[r*3+1] = win_q[r*3+2];
        view[r*3+2] = 8'd0;
      end
      top   = (row_q == c3er_pkg::ROW_W'(2));
      bot   = (row_q == h_ext + c3er_pkg::ROW_W'(1));
      left  = 1'b0;
      right = 1'b1;
    end

    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((r == 0 && top) || (r == 2 && bot) || (c == 0 && left) || (c == 2 && right)) begin
          q_job_o.view[r*3+c] = view[4];
        end else begin
          q_job_o.view[r*3+c] = view[r*3+c];
        end
      end
    end

    done         = (cnt_q == geom_i.total - c3er_pkg::TOT_W'(1));
    q_job_o.done = done;
    q_push_o     = upd && have;

    col_inc = c3er_pkg::CMP_W'(col_q) + c3er_pkg::CMP_W'(1);
    col_d   = col_q;
    row_d   = row_q;
    cnt_d   = cnt_q;
    if (geom_i.restart) begin
      col_d = '0;
      row_d = '0;
      cnt_d = '0;
    end else if (upd) begin
      if (col_inc >= geom_i.eff_w) begin
        col_d = '0;
        row_d = row_q + c3er_pkg::ROW_W'(1);
      end else begin
        col_d = col_inc[c3er_pkg::ADDR_W-1:0];
      end
      if (have) begin
        if (done) begin
          col_d = '0;
          row_d = '0;
          cnt_d = '0;
        end else begin
          cnt_d = cnt_q + c3er_pkg::TOT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= c3er_pkg::F_ACC;
      col_q   <= '0;
      row_q   <= '0;
      cnt_q   <= '0;
      win_q   <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      cnt_q   <= cnt_d;
      if (upd) win_q <= win_d;
    end
  end

endmodule

FILE: rtl/core/c3er_queue.sv
// ----------------------------------------------------------------------------
// c3er_queue
// Two-entry queue of views between the front and the arithmetic back end.
// ----------------------------------------------------------------------------
module c3er_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  c3er_pkg::job_t  job_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            avail_o,
  output c3er_pkg::job_t  job_o
);

  c3er_pkg::job_t slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign job_o   = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

FILE: rtl/core/c3er_back.sv
// ----------------------------------------------------------------------------
// c3er_back
// Serial multiply-accumulate over the nine taps, bit-serial division and
// clamping, with the result held in the output register.
// ----------------------------------------------------------------------------
module c3er_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  c3er_pkg::arith_t    arith_i,
  input  logic                avail_i,
  input  c3er_pkg::job_t      job_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output c3er_pkg::out_item_t out_data_o
);

  c3er_pkg::b_state_e state_q, state_d;

  c3er_pkg::job_t                    job_q;
  logic [3:0]                        tap_q;
  logic signed [c3er_pkg::PROD_W-1:0] prod_q;
  logic signed [c3er_pkg::SUM_W-1:0]  acc_q;
  logic [c3er_pkg::MAG_W-1:0]        dvd_q;
  logic [15:0]                       rem_q;
  logic [c3er_pkg::STEP_W-1:0]       step_q;
  logic [7:0]                        res_q;

  logic        mac_end, div_end, neg;
  logic signed [c3er_pkg::SUM_W-1:0] sum_all;
  logic [15:0] dv;
  logic [16:0] shifted, trial;

  assign mac_end = (tap_q == 4'd9);
  assign div_end = (step_q == c3er_pkg::STEP_W'(c3er_pkg::MAG_W - 1));
  // The last product is still outside the accumulator on the final tap.
  assign sum_all = acc_q + c3er_pkg::SUM_W'(prod_q);
  assign neg     = sum_all[c3er_pkg::SUM_W-1];
  assign dv      = (arith_i.divisor == 16'd0) ? 16'd1 : arith_i.divisor;
  assign shifted = {rem_q, dvd_q[c3er_pkg::MAG_W-1]};
  assign trial   = shifted - {1'b0, dv};

  always_comb begin
    state_d = state_q;
    case (state_q)
      c3er_pkg::B_IDLE: if (avail_i) state_d = c3er_pkg::B_MAC;
      c3er_pkg::B_MAC:  if (mac_end) state_d = neg ? c3er_pkg::B_OUT : c3er_pkg::B_DIV;
      c3er_pkg::B_DIV:  if (div_end) state_d = c3er_pkg::B_OUT;
      c3er_pkg::B_OUT:  if (out_ready_i) state_d = c3er_pkg::B_IDLE;
      default:          state_d = c3er_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      c3er_pkg::B_IDLE: pop_o = avail_i;
      c3er_pkg::B_OUT:  out_valid_o = 1'b1;
      default:          pop_o = 1'b0;
    endcase
  end

  assign out_data_o.filtered_pixel = res_q;
  assign out_data_o.frame_done     = job_q.done;

  always_ff @(posedge clk_i) begin
    case (state_q)
      c3er_pkg::B_IDLE: begin
        job_q <= job_i;
        acc_q <= '0;
      end
      c3er_pkg::B_MAC: begin
        if (tap_q != 4'd9) begin
          prod_q <= c3er_pkg::coeff(arith_i, tap_q) * $signed({1'b0, job_q.view[tap_q]});
        end
        if (tap_q != 4'd0) begin
          acc_q <= acc_q + c3er_pkg::SUM_W'(prod_q);
        end
        // A negative sum skips the division and clamps to zero.
        dvd_q <= acc_q[c3er_pkg::MAG_W-1:0] + c3er_pkg::MAG_W'(prod_q);
        rem_q <= 16'd0;
        res_q <= 8'd0;
      end
      c3er_pkg::B_DIV: begin
        if (!trial[16]) begin
          rem_q <= trial[15:0];
        end else begin
          rem_q <= shifted[15:0];
        end
        dvd_q <= {dvd_q[c3er_pkg::MAG_W-2:0], !trial[16]};
        if (div_end) begin
          if ({dvd_q[c3er_pkg::MAG_W-2:0], !trial[16]} > c3er_pkg::MAG_W'(255)) begin
            res_q <= 8'hFF;
          end else begin
            res_q <= dvd_q[6:0] << 1 | 8'(!trial[16]);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= c3er_pkg::B_IDLE;
      tap_q   <= 4'd0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == c3er_pkg::B_MAC && !mac_end) tap_q <= tap_q + 4'd1;
      else tap_q <= 4'd0;
      if (state_q == c3er_pkg::B_DIV) step_q <= step_q + c3er_pkg::STEP_W'(1);
      else step_q <= '0;
    end
  end

endmodule

FILE: rtl/core/conv3x3_edge_replicate_unit.sv
// ----------------------------------------------------------------------------
// conv3x3_edge_replicate_unit
// Streaming 3x3 convolution of 8-bit grey pixels with edge replication,
// divisor normalization and clamping to 0..255.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  in      | input     | in_valid_i/ready_o  | in_data_i  (operation, pixel)
//  out     | output    | out_valid_o/ready_i | out_data_o (pixel, frame_done)
//  cfg     | input     | cfg_valid_i/ready_o | cfg_index_i, cfg_data_i
//
//  The front cannot take a new input transfer before the last one is through
//  its window update: the line-store read is registered and the window
//  update follows. A result leaves the queue, passes the serial
//  multiply-accumulate in the back end and the bit-serial division
//  (skipped for a negative sum), and then waits in the output register until
//  it is taken.
//  A two-entry queue lets the front keep accepting while results stall, until it is full.
//  Reset returns the registers to their defaults and the frame position to
//  zero; the line stores are not cleared and need no clearing pass.
//
module conv3x3_edge_replicate_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  c3er_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output c3er_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [47:0]         cfg_data_i
);

  logic [10:0]            fw_q;
  logic [12:0]            fh_q;
  c3er_pkg::arith_t       arith_q;
  c3er_pkg::geom_t        geom;
  logic                   cfg_wr;

  logic                   q_push, q_full, q_pop, q_avail;
  c3er_pkg::job_t         q_in, q_out;

  // Configuration writes are always taken; the user must send them only while idle, the block does not enforce it.
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q            <= 11'd640;
      fh_q            <= 13'd480;
      arith_q.k_top   <= 48'd0;
      arith_q.k_mid   <= 48'd65536;
      arith_q.k_bot   <= 48'd0;
      arith_q.divisor <= 16'd1;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        c3er_pkg::CFG_WIDTH:   fw_q            <= cfg_data_i[10:0];
        c3er_pkg::CFG_HEIGHT:  fh_q            <= cfg_data_i[12:0];
        c3er_pkg::CFG_KTOP:    arith_q.k_top   <= cfg_data_i;
        c3er_pkg::CFG_KMID:    arith_q.k_mid   <= cfg_data_i;
        c3er_pkg::CFG_KBOT:    arith_q.k_bot   <= cfg_data_i;
        c3er_pkg::CFG_DIVISOR: arith_q.divisor <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Effective geometry: width and height are held to their legal ranges.
  always_comb begin
    if (c3er_pkg::CMP_W'(fw_q) < c3er_pkg::CMP_W'(2)) begin
      geom.eff_w = c3er_pkg::CMP_W'(2);
    end else if (c3er_pkg::CMP_W'(fw_q) > c3er_pkg::CMP_W'(c3er_pkg::MAX_WIDTH)) begin
      geom.eff_w = c3er_pkg::CMP_W'(c3er_pkg::MAX_WIDTH);
    end else begin
      geom.eff_w = c3er_pkg::CMP_W'(fw_q);
    end
    if (fh_q < 13'd2) begin
      geom.eff_h = 13'd2;
    end else if (fh_q > c3er_pkg::HGT_W'(c3er_pkg::MAX_HEIGHT)) begin
      geom.eff_h = c3er_pkg::HGT_W'(c3er_pkg::MAX_HEIGHT);
    end else begin
      geom.eff_h = fh_q;
    end
    geom.total   = c3er_pkg::TOT_W'(geom.eff_w) * c3er_pkg::TOT_W'(geom.eff_h);
    // A geometry write starts the frame over.
    geom.restart = cfg_wr && (cfg_index_i == c3er_pkg::CFG_WIDTH ||
                              cfg_index_i == c3er_pkg::CFG_HEIGHT);
  end

  c3er_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .geom_i     (geom),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (q_in)
  );

  c3er_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .avail_o (q_avail),
    .job_o   (q_out)
  );

  c3er_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .arith_i     (arith_q),
    .avail_i     (q_avail),
    .job_i       (q_out),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: rtl/core/c3er_checker.sv
// ----------------------------------------------------------------------------
// c3er_checker
// Port-level checks of the convolution unit, bound to the top level.
// ----------------------------------------------------------------------------
module c3er_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input c3er_pkg::out_item_t out_data_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // After a result is taken the back end returns to idle, so none follows directly.
  a_out_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> !out_valid_o)
    else $error("back-to-back results");

  // The front spends the cycle after an input transfer on its update.
  a_in_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken during window update");

endmodule

bind conv3x3_edge_replicate_unit c3er_checker u_c3er_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for conv3x3_edge_replicate_unit. A local model of
// the window, line stores and normalizer predicts each filtered pixel from
// the input transfers, and a monitor compares every output transfer with
// the oldest prediction. Directed frames exercise the extremes, followed by
// randomized frames with random geometry, kernels, divisors and idling.
// ----------------------------------------------------------------------------
module tb;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;
  // Allowance after the last result before configuration or the end; a
  // pixel-only item can still be in flight in the front.
  localparam int SETTLE_CYCLES = 300;
  localparam int LONG_HOLD     = 500;

  logic                c3er_clk_unused;
  logic                clk = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  c3er_pkg::in_item_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  c3er_pkg::out_item_t out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [2:0]          cfg_index_i = '0;
  logic [47:0]         cfg_data_i = '0;

  conv3x3_edge_replicate_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  assign c3er_clk_unused = clk;

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Local model of the filter: its own copy of the registers and state.
  // --------------------------------------------------------------------------
  logic [10:0]     width_reg;
  logic [12:0]     height_reg;
  logic [47:0]     kernel_reg [3];
  logic [15:0]     divisor_reg;
  logic [7:0]      row_above [1024];
  logic [7:0]      row_above2 [1024];
  logic [8:0][7:0] window;
  int unsigned     col_pos, row_pos, outs_in_frame;

  c3er_pkg::in_item_t  pixel_q [$];     // items waiting to be offered
  c3er_pkg::out_item_t filtered_q [$];  // predicted results, oldest first

  int errors = 0;
  int n_results = 0;
  int n_frames = 0;
  int n_items = 0;
  int n_stalled = 0;

  function automatic int unsigned eff_width();
    if (width_reg < 2) return 2;
    if (width_reg > c3er_pkg::MAX_WIDTH) return c3er_pkg::MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg < 2) return 2;
    if (height_reg > c3er_pkg::MAX_HEIGHT) return c3er_pkg::MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic void restart_frame();
    col_pos = 0;
    row_pos = 0;
    outs_in_frame = 0;
  endfunction

  function automatic void model_reset();
    width_reg     = 11'd640;
    height_reg    = 13'd480;
    kernel_reg[0] = 48'd0;
    kernel_reg[1] = 48'd65536;
    kernel_reg[2] = 48'd0;
    divisor_reg   = 16'd1;
    window        = '0;
    for (int i = 0; i < 1024; i++) begin
      row_above[i]  = 8'd0;
      row_above2[i] = 8'd0;
    end
    restart_frame();
  endfunction

  function automatic void model_config(logic [2:0] idx, logic [47:0] d);
    case (idx)
      c3er_pkg::CFG_WIDTH: begin
        width_reg = d[10:0];
        restart_frame();
      end
      c3er_pkg::CFG_HEIGHT: begin
        height_reg = d[12:0];
        restart_frame();
      end
      c3er_pkg::CFG_KTOP:    kernel_reg[0] = d;
      c3er_pkg::CFG_KMID:    kernel_reg[1] = d;
      c3er_pkg::CFG_KBOT:    kernel_reg[2] = d;
      c3er_pkg::CFG_DIVISOR: divisor_reg = d[15:0];
      default: ;
    endcase
  endfunction

  // Weighted sum of a 3x3 view with out-of-frame neighbors replaced by the
  // center, divided toward zero and clamped to the pixel range.
  function automatic logic [7:0] weigh_window(logic [8:0][7:0] v, bit top, bit bot,
                                              bit left, bit right);
    longint sum;
    longint dv;
    logic [15:0] raw;
    logic [7:0] px;
    bit outside;
    sum = 0;
    dv = (divisor_reg == 0) ? 1 : longint'(divisor_reg);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        outside = (r == 0 && top) || (r == 2 && bot) || (c == 0 && left) ||
                  (c == 2 && right);
        px = outside ? v[4] : v[r*3+c];
        raw = kernel_reg[r][16*c +: 16];
        sum += longint'($signed(raw)) * longint'(px);
      end
    end
    sum = sum / dv;
    if (sum < 0) sum = 0;
    if (sum > 255) sum = 255;
    return sum[7:0];
  endfunction

  // Advances the model by one accepted input item and queues its result, if it completes one.
  function automatic void take_item(c3er_pkg::in_item_t it);
    int unsigned w, h, total, pos, ci, ro;
    logic [8:0][7:0] view;
    logic [7:0] px, res;
    c3er_pkg::out_item_t e;
    bit have;
    w = eff_width();
    h = eff_height();
    total = w * h;
    pos = row_pos * w + col_pos;
    // A drain while frame pixels are still due is dropped entirely.
    if (pos < total && it.operation == OP_DRAIN) return;
    px = (pos < total) ? it.pixel_value : 8'd0;
    ci = col_pos;
    have = 0;
    res = '0;
    // Column zero of a new row finishes the right-hand pixel of the row
    // two above, using the window as it stands before the shift.
    if (ci == 0 && pos >= w + 1) begin
      ro = row_pos - 2;
      for (int r = 0; r < 3; r++) begin
        view[r*3]   = window[r*3+1];
        view[r*3+1] = window[r*3+2];
        view[r*3+2] = 8'd0;
      end
      res = weigh_window(view, ro == 0, ro == h - 1, 1'b0, 1'b1);
      have = 1;
    end
    for (int r = 0; r < 3; r++) begin
      window[r*3]   = window[r*3+1];
      window[r*3+1] = window[r*3+2];
    end
    window[2] = row_above2[ci];
    window[5] = row_above[ci];
    window[8] = px;
    row_above2[ci] = row_above[ci];
    row_above[ci]  = px;
    if (ci >= 1 && pos >= w + 1) begin
      ro = row_pos - 1;
      res = weigh_window(window, ro == 0, ro == h - 1, ci == 1, 1'b0);
      have = 1;
    end
    col_pos = ci + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (have) begin
      e.filtered_pixel = res;
      e.frame_done = (outs_in_frame == total - 1);
      filtered_q.push_back(e);
      if (e.frame_done) restart_frame();
      else outs_in_frame++;
    end
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // --------------------------------------------------------------------------
  // Monitor: samples both channels at the rising edge. The output side is
  // checked first; a result never comes from the item of the same edge.
  // --------------------------------------------------------------------------
  logic in_xfer = 1'b0;

  always @(posedge clk) begin
    c3er_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (filtered_q.size() == 0) begin
        report("unexpected result, pixel", out_data_o.filtered_pixel, -1);
      end else begin
        want = filtered_q.pop_front();
        if (out_data_o.filtered_pixel !== want.filtered_pixel)
          report("filtered_pixel", out_data_o.filtered_pixel, want.filtered_pixel);
        if (out_data_o.frame_done !== want.frame_done)
          report("frame_done", out_data_o.frame_done, want.frame_done);
        if (want.frame_done) n_frames++;
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      take_item(in_data_i);
      n_items++;
    end
    if (rst_ni && in_valid_i && !in_ready_o) n_stalled++;
    in_xfer <= rst_ni && in_valid_i && in_ready_o;
  end

  // --------------------------------------------------------------------------
  // Driver: offers queued items at the falling edge, with random gaps. A
  // pending item is held until its transfer has been seen.
  // --------------------------------------------------------------------------
  bit calm = 0;  // set for the final stretch: no idling on either side
  int send_gap = 0;

  always @(negedge clk) begin
    logic nv;
    c3er_pkg::in_item_t nd;
    if (rst_ni) begin
      nv = in_valid_i;
      nd = in_data_i;
      if (!in_valid_i || in_xfer) begin
        if (in_valid_i) void'(pixel_q.pop_front());
        nv = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 15) - 1;
        end else if (pixel_q.size() > 0) begin
          nv = 1'b1;
          nd = pixel_q[0];
        end
      end
      in_valid_i <= nv;
      in_data_i  <= nd;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts plus, on request, one long hold-off that
  // lets the block fill up and stall its input side.
  // --------------------------------------------------------------------------
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;
  int stall_left = 0;

  always @(negedge clk) begin
    logic rdy;
    rdy = 1'b1;
    if (hold_asked != hold_served) begin
      hold_served++;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      rdy = 1'b0;
    end
    out_ready_i <= rdy;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic cfg_write(logic [2:0] idx, logic [47:0] d);
    @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk); while (!cfg_ready_o);
    model_config(idx, d);
    @(negedge clk);
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every queued item has gone in and every result came out,
  // then lets the back end settle so that configuration is safe.
  task automatic wait_idle();
    while (pixel_q.size() > 0 || in_valid_i || filtered_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void push_item(logic op, logic [7:0] px);
    c3er_pkg::in_item_t it;
    it.operation = op;
    it.pixel_value = px;
    pixel_q.push_back(it);
  endfunction

  // Queues npix pixels of a frame in the current geometry, with the odd
  // premature drain mixed in; a full frame also gets its flush, where some
  // steps are pixel items that the block must treat as drains.
  function automatic int push_frame(int npix, bit full);
    int w;
    w = eff_width();
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(0, 29) == 0) push_item(OP_DRAIN, 8'($urandom));
      push_item(OP_PIXEL, 8'($urandom));
    end
    if (full) begin
      for (int i = 0; i <= w; i++)
        push_item($urandom_range(0, 3) == 0 ? OP_PIXEL : OP_DRAIN, 8'($urandom));
      return npix + w + 1;
    end
    return npix;
  endfunction

  function automatic logic [47:0] rand_kernel_row(bit wide);
    logic [47:0] k;
    int c;
    for (int i = 0; i < 3; i++) begin
      c = $urandom_range(0, 8) - 4;
      k[16*i +: 16] = wide ? 16'($urandom) : c[15:0];
    end
    return k;
  endfunction

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    int sent;
    int w, h;
    bit wide;
    model_reset();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // Small 3x2 frame with extreme coefficients and pixel values; one drain
    // arrives too early and one flush step carries a pixel.
    cfg_write(c3er_pkg::CFG_WIDTH, 48'd3);
    cfg_write(c3er_pkg::CFG_HEIGHT, 48'd2);
    cfg_write(c3er_pkg::CFG_KTOP, {16'h7FFF, 16'h8000, 16'h0001});
    cfg_write(c3er_pkg::CFG_KMID, {16'hFFFF, 16'h0008, 16'h0000});
    cfg_write(c3er_pkg::CFG_KBOT, {16'h8000, 16'h7FFF, 16'h0002});
    cfg_write(c3er_pkg::CFG_DIVISOR, 48'd3);
    push_item(OP_PIXEL, 8'd0);
    push_item(OP_PIXEL, 8'd255);
    push_item(OP_DRAIN, 8'd17);
    push_item(OP_PIXEL, 8'h55);
    push_item(OP_PIXEL, 8'hAA);
    push_item(OP_PIXEL, 8'd255);
    push_item(OP_PIXEL, 8'd0);
    push_item(OP_DRAIN, 8'd0);
    push_item(OP_PIXEL, 8'd200);
    push_item(OP_DRAIN, 8'd0);
    push_item(OP_DRAIN, 8'd0);
    wait_idle();

    // Widths and heights below the minimum act as 2; a zero divisor acts as
    // one, and a kernel negative but for its center must clamp negative sums to zero.
    cfg_write(c3er_pkg::CFG_WIDTH, 48'd1);
    cfg_write(c3er_pkg::CFG_HEIGHT, 48'd0);
    cfg_write(c3er_pkg::CFG_KTOP, {3{16'hFFFF}});
    cfg_write(c3er_pkg::CFG_KMID, {16'hFFFF, 16'h0009, 16'hFFFF});
    cfg_write(c3er_pkg::CFG_KBOT, {3{16'hFFFF}});
    cfg_write(c3er_pkg::CFG_DIVISOR, 48'd0);
    push_item(OP_PIXEL, 8'd255);
    push_item(OP_PIXEL, 8'd1);
    push_item(OP_PIXEL, 8'd128);
    push_item(OP_PIXEL, 8'd127);
    push_item(OP_DRAIN, 8'd0);
    push_item(OP_DRAIN, 8'd0);
    push_item(OP_DRAIN, 8'd0);
    wait_idle();

    // Tallest frame, cut short; the geometry write that follows restarts it.
    cfg_write(c3er_pkg::CFG_WIDTH, 48'd0);
    cfg_write(c3er_pkg::CFG_HEIGHT, 48'd8191);
    cfg_write(c3er_pkg::CFG_DIVISOR, 48'd65535);
    sent = push_frame(40, 0);
    wait_idle();

    // Widest frame over an oversized width, cut short a little past the
    // first row. Once results start, a long hold-off on the output makes
    // the block back up into its input.
    cfg_write(c3er_pkg::CFG_WIDTH, 48'd2047);
    cfg_write(c3er_pkg::CFG_HEIGHT, 48'd1);
    cfg_write(c3er_pkg::CFG_KTOP, rand_kernel_row(0));
    cfg_write(c3er_pkg::CFG_KMID, {16'h0001, 16'h0004, 16'h0001});
    cfg_write(c3er_pkg::CFG_KBOT, rand_kernel_row(0));
    cfg_write(c3er_pkg::CFG_DIVISOR, 48'd4);
    sent = push_frame(eff_width() + 24, 0);
    while (filtered_q.size() == 0) @(posedge clk);
    hold_asked++;
    wait_idle();

    // Random frames fill out the rest of the run; some are cut short and
    // then restarted by the next geometry write.
    sent = 0;
    while (sent < 200) begin
      calm = (sent > 140);
      w = $urandom_range(0, 5) == 0 ? $urandom_range(0, 40) : $urandom_range(2, 12);
      h = $urandom_range(0, 7) == 0 ? $urandom_range(0, 16) : $urandom_range(2, 6);
      wide = ($urandom_range(0, 2) == 0);
      cfg_write(c3er_pkg::CFG_WIDTH, 48'(w));
      cfg_write(c3er_pkg::CFG_HEIGHT, 48'(h));
      cfg_write(c3er_pkg::CFG_KTOP, rand_kernel_row(wide));
      cfg_write(c3er_pkg::CFG_KMID, rand_kernel_row(wide));
      cfg_write(c3er_pkg::CFG_KBOT, rand_kernel_row(wide));
      case ($urandom_range(0, 5))
        0:       cfg_write(c3er_pkg::CFG_DIVISOR, 48'($urandom_range(0, 65535)));
        1:       cfg_write(c3er_pkg::CFG_DIVISOR, 48'd0);
        default: cfg_write(c3er_pkg::CFG_DIVISOR, 48'($urandom_range(1, 16)));
      endcase
      if (!calm && $urandom_range(0, 5) == 0) begin
        sent += push_frame($urandom_range(1, eff_width() * eff_height()), 0);
      end else begin
        repeat ($urandom_range(1, 2)) sent += push_frame(eff_width() * eff_height(), 1);
      end
      wait_idle();
    end

    $display("checked %0d results over %0d finished frames from %0d input transfers",
             n_results, n_frames, n_items);
    $display("input side was held off for %0d cycles", n_stalled);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(4 * 3000000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
